FILE: hdl/mmcg_pkg.sv
// Shared types, codes and the per-mode command allow table of the mode command gate.
package mmcg_pkg;

  localparam int unsigned NumGated = 21;

  // Event kinds
  typedef enum logic [2:0] {
    ACT_COMMAND = 3'd0,
    ACT_TICK    = 3'd1,
    ACT_BUTTON  = 3'd2,
    ACT_ESTOP   = 3'd3,
    ACT_FAULT   = 3'd4
  } act_e;

  // Command codes with behaviour of their own
  typedef enum logic [4:0] {
    CMD_HOME        = 5'd0,
    CMD_RUN_PROGRAM = 5'd2,
    CMD_PAUSE       = 5'd3,
    CMD_RESUME      = 5'd4,
    CMD_RESET_FAULT = 5'd5,
    CMD_RESET_ESTOP = 5'd6,
    CMD_ESTOP       = 5'd21,
    CMD_LAST_ALWAYS = 5'd26
  } cmd_e;

  typedef enum logic [1:0] {
    BTN_START = 2'd0,
    BTN_PAUSE = 2'd1
  } btn_e;

  typedef enum logic [2:0] {
    NK_NONE     = 3'd0,
    NK_UNKNOWN  = 3'd1,
    NK_ESTOP    = 3'd2,
    NK_HWFAULT  = 3'd3,
    NK_NOTREADY = 3'd4,
    NK_NOPROG   = 3'd5
  } nack_e;

  // Machine mode, one-hot; bit m stands for mode code m
  typedef enum logic [6:0] {
    MODE_IDLE     = 7'b0000001,
    MODE_HOMING   = 7'b0000010,
    MODE_READY    = 7'b0000100,
    MODE_RUNNING  = 7'b0001000,
    MODE_PAUSED   = 7'b0010000,
    MODE_FAULTED  = 7'b0100000,
    MODE_ESTOPPED = 7'b1000000
  } mode_e;

  localparam logic [2:0] ModeCodeIdle     = 3'd0;
  localparam logic [2:0] ModeCodeHoming   = 3'd1;
  localparam logic [2:0] ModeCodeReady    = 3'd2;
  localparam logic [2:0] ModeCodeRunning  = 3'd3;
  localparam logic [2:0] ModeCodePaused   = 3'd4;
  localparam logic [2:0] ModeCodeFaulted  = 3'd5;
  localparam logic [2:0] ModeCodeEstopped = 3'd6;

  localparam logic [7:0]  FaultNone           = 8'd0;
  localparam logic [7:0]  FaultEstopTriggered = 8'd1;
  localparam logic [15:0] HomingTimeReset     = 16'd3000;

  // Modes in which each gated command is allowed, bit m for mode code m
  localparam logic [6:0] GATE_MASK [NumGated] = '{
    7'h05, 7'h05, 7'h04, 7'h08, 7'h10, 7'h20, 7'h40, 7'h04, 7'h04, 7'h65, 7'h04,
    7'h05, 7'h05, 7'h05, 7'h05, 7'h05, 7'h05, 7'h05, 7'h7D, 7'h05, 7'h05
  };

  typedef struct packed {
    logic [2:0]  action;
    logic [4:0]  command_code;
    logic [15:0] command_tag;
    logic [31:0] now_ms;
    logic [1:0]  button_code;
    logic        estop_level;
    logic [7:0]  fault_reason;
    logic        program_loaded;
  } event_t;

  typedef struct packed {
    logic        reply_kind;
    logic [15:0] reply_tag;
    logic [4:0]  reply_command;
    nack_e       nack_reason;
    logic [2:0]  mode_now;
    logic        estop_latched;
    logic [7:0]  fault_now;
  } reply_t;

  typedef logic [15:0] cfg_word_t;

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] c;
    unique case (m)
      MODE_IDLE:     c = ModeCodeIdle;
      MODE_HOMING:   c = ModeCodeHoming;
      MODE_READY:    c = ModeCodeReady;
      MODE_RUNNING:  c = ModeCodeRunning;
      MODE_PAUSED:   c = ModeCodePaused;
      MODE_FAULTED:  c = ModeCodeFaulted;
      MODE_ESTOPPED: c = ModeCodeEstopped;
      default:       c = ModeCodeIdle;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/mmcg_chan_if.sv
// Valid/ready channel carrying one payload word.
interface mmcg_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/mmcg_in_stage.sv
// Input register: holds one accepted event word until the core consumes it.
module mmcg_in_stage import mmcg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  event_t data_i,
  output logic   item_valid_o,
  output event_t item_o,
  input  logic   consume_i
);

  logic   valid_q, valid_d;
  event_t data_q;

  assign ready_o = !valid_q || consume_i;
  assign valid_d = valid_i || (valid_q && !consume_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

FILE: hdl/mmcg_core.sv
// Mode state, homing deadline, estop latch, fault code and the per-event decision logic.
module mmcg_core import mmcg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  input  cfg_word_t cfg_data_i,
  input  logic      item_valid_i,
  input  event_t    item_i,
  input  logic      out_space_i,
  output logic      consume_o,
  output logic      reply_valid_o,
  output reply_t    reply_o
);

  mode_e       mode_q, mode_d;
  logic [31:0] deadline_q, deadline_d;
  logic        latch_q, latch_d;
  logic [7:0]  fault_q, fault_d;
  cfg_word_t   homing_q;
  logic        has_reply;
  nack_e       nk;
  logic [31:0] tick_diff;

  assign tick_diff = item_i.now_ms - deadline_q;

  always_comb begin
    mode_d     = mode_q;
    deadline_d = deadline_q;
    latch_d    = latch_q;
    fault_d    = fault_q;
    nk         = NK_NONE;
    has_reply  = 1'b0;
    unique case (item_i.action)
      ACT_COMMAND: begin
        has_reply = 1'b1;
        if (item_i.command_code == CMD_ESTOP) begin
          latch_d = 1'b1;
          fault_d = FaultEstopTriggered;
          mode_d  = MODE_ESTOPPED;
        end else if (item_i.command_code > CMD_LAST_ALWAYS) begin
          nk = NK_UNKNOWN;
        end else if (item_i.command_code > CMD_ESTOP) begin
          nk = NK_NONE;
        end else if ((GATE_MASK[item_i.command_code] & mode_q) == 7'd0) begin
          if (mode_q == MODE_ESTOPPED) begin
            nk = NK_ESTOP;
          end else if (mode_q == MODE_FAULTED) begin
            nk = NK_HWFAULT;
          end else begin
            nk = NK_NOTREADY;
          end
        end else begin
          case (item_i.command_code)
            CMD_HOME: begin
              mode_d     = MODE_HOMING;
              deadline_d = item_i.now_ms + {16'd0, homing_q};
            end
            CMD_RUN_PROGRAM: begin
              if (!item_i.program_loaded) begin
                nk = NK_NOPROG;
              end else begin
                mode_d = MODE_RUNNING;
              end
            end
            CMD_PAUSE:  mode_d = MODE_PAUSED;
            CMD_RESUME: mode_d = MODE_RUNNING;
            CMD_RESET_FAULT: begin
              fault_d = FaultNone;
              mode_d  = MODE_IDLE;
            end
            CMD_RESET_ESTOP: begin
              if (latch_q) begin
                nk = NK_HWFAULT;
              end else begin
                fault_d = FaultNone;
                mode_d  = MODE_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      ACT_TICK: begin
        // wrap-safe: deadline reached when the signed difference is not negative
        if (mode_q == MODE_HOMING && !tick_diff[31]) begin
          mode_d = MODE_READY;
        end
      end
      ACT_BUTTON: begin
        if (item_i.button_code == BTN_START) begin
          if (mode_q == MODE_IDLE) begin
            mode_d     = MODE_HOMING;
            deadline_d = item_i.now_ms + {16'd0, homing_q};
          end else if (mode_q == MODE_READY) begin
            if (item_i.program_loaded) begin
              mode_d = MODE_RUNNING;
            end
          end else if (mode_q == MODE_PAUSED) begin
            mode_d = MODE_RUNNING;
          end
        end else if (item_i.button_code == BTN_PAUSE) begin
          if (mode_q == MODE_RUNNING) begin
            mode_d = MODE_PAUSED;
          end else if (mode_q == MODE_FAULTED) begin
            fault_d = FaultNone;
            mode_d  = MODE_IDLE;
          end
        end
      end
      ACT_ESTOP: begin
        latch_d = item_i.estop_level;
        if (item_i.estop_level) begin
          fault_d = FaultEstopTriggered;
          mode_d  = MODE_ESTOPPED;
        end else if (mode_q == MODE_ESTOPPED) begin
          fault_d = FaultNone;
          mode_d  = MODE_IDLE;
        end
      end
      ACT_FAULT: begin
        if (mode_q != MODE_ESTOPPED) begin
          fault_d = item_i.fault_reason;
          mode_d  = MODE_FAULTED;
        end
      end
      default: ;
    endcase
  end

  // Stall only when a reply is due and the result register is still full
  assign consume_o     = item_valid_i && (!has_reply || out_space_i);
  assign reply_valid_o = consume_o && has_reply;

  always_comb begin
    reply_o.reply_kind    = (nk != NK_NONE);
    reply_o.reply_tag     = item_i.command_tag;
    reply_o.reply_command = item_i.command_code;
    reply_o.nack_reason   = nk;
    reply_o.mode_now      = mode_code(mode_d);
    reply_o.estop_latched = latch_d;
    reply_o.fault_now     = fault_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      deadline_q <= 32'd0;
      latch_q    <= 1'b0;
      fault_q    <= FaultNone;
      homing_q   <= HomingTimeReset;
    end else begin
      if (consume_o) begin
        mode_q     <= mode_d;
        deadline_q <= deadline_d;
        latch_q    <= latch_d;
        fault_q    <= fault_d;
      end
      if (cfg_valid_i) begin
        homing_q <= cfg_data_i;
      end
    end
  end

  // The latch can only be engaged while the machine sits in estop
  a_latch_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q |-> mode_q == MODE_ESTOPPED)
    else $error("estop latch engaged outside estopped mode");

  // Idle is only reached with the fault code cleared
  a_idle_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_IDLE |-> fault_q == FaultNone)
    else $error("fault code held in idle mode");

  // A tick never touches the fault code or the latch
  a_tick_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume_o && item_i.action == ACT_TICK |=> $stable(fault_q) && $stable(latch_q))
    else $error("tick changed fault or latch");

endmodule

FILE: hdl/mmcg_out_stage.sv
// Result register: holds one reply word until the receiver takes it.
module mmcg_out_stage import mmcg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  reply_t data_i,
  output logic   space_o,
  output logic   valid_o,
  input  logic   ready_i,
  output reply_t data_o
);

  logic   valid_q, valid_d;
  reply_t data_q;

  assign space_o = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // An ack carries no reason, a nack always carries one
  a_kind_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> data_q.reply_kind == (data_q.nack_reason != NK_NONE))
    else $error("reply kind disagrees with nack reason");

endmodule

FILE: hdl/machine_mode_command_gate_unit.sv
// Top level of the machine-mode command gate.
//
// Channels: evt_i carries one event word (command, tick, button, estop line
// change or fault report); res_o carries one reply word for each command
// event and nothing for the other events; cfg_i writes the homing time in ms.
// The config channel is always ready.
// Path: an event is registered in the input register on acceptance and
// decided from there; a command's reply is then loaded into the result
// register, where it is held valid until the receiver takes it.
// Throughput: one event per cycle while the result register has space for
// each reply. The mode update, homing deadline add and wrap-safe compare
// settle between the input and result registers.
// Reset: mode idle, latch clear, no fault, deadline 0, homing time 3000 ms,
// both channel registers empty.
// Stall: while res_o holds an untaken reply, one more event is held in the
// input register; a command behind it waits, and evt_i stays ready as long
// as the held event can still move on.
module machine_mode_command_gate_unit import mmcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mmcg_chan_if.sink   cfg_i,
  mmcg_chan_if.sink   evt_i,
  mmcg_chan_if.source res_o
);

  logic   item_valid;
  event_t item;
  logic   consume;
  logic   reply_valid;
  reply_t reply;
  logic   out_space;

  assign cfg_i.ready = 1'b1;

  mmcg_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (evt_i.valid),
    .ready_o      (evt_i.ready),
    .data_i       (evt_i.data),
    .item_valid_o (item_valid),
    .item_o       (item),
    .consume_i    (consume)
  );

  mmcg_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .out_space_i   (out_space),
    .consume_o     (consume),
    .reply_valid_o (reply_valid),
    .reply_o       (reply)
  );

  mmcg_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (reply_valid),
    .data_i  (reply),
    .space_o (out_space),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (res_o.data)
  );

endmodule

FILE: tb/machine_mode_command_gate_unit_test.sv
// Self-checking testbench for the machine-mode command gate: random and directed events, reply check.
module machine_mode_command_gate_unit_test import mmcg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 6;
  localparam logic [1:0]  BtnIgnored  = 2'd3;

  // Modes that allow each gated command, bit m for mode code m
  localparam logic [6:0] AllowedModes [NumGated] = '{
    7'h05, 7'h05, 7'h04, 7'h08, 7'h10, 7'h20, 7'h40, 7'h04, 7'h04, 7'h65, 7'h04,
    7'h05, 7'h05, 7'h05, 7'h05, 7'h05, 7'h05, 7'h05, 7'h7D, 7'h05, 7'h05
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  mmcg_chan_if #(.payload_t(cfg_word_t)) cfg_ch ();
  mmcg_chan_if #(.payload_t(event_t))    evt_ch ();
  mmcg_chan_if #(.payload_t(reply_t))    res_ch ();

  machine_mode_command_gate_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .evt_i  (evt_ch),
    .res_o  (res_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predicted state of the gate
  logic [2:0]  mode_q;
  logic [31:0] deadline_q;
  logic        latch_q;
  logic [7:0]  fault_q;
  logic [15:0] homing_ms_q;

  event_t      pending_events[$];
  reply_t      expected_replies[$];
  int unsigned pushed_total;
  int unsigned accepted_total;
  int unsigned planned_items;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned silent_cycles;
  logic [31:0] gen_ms;

  wire quiet_stretch = (cycle_count % 2500) < 300;

  task automatic set_estop_line(input logic level);
    latch_q = level;
    if (level) begin
      fault_q = FaultEstopTriggered;
      mode_q  = ModeCodeEstopped;
    end else if (mode_q == ModeCodeEstopped) begin
      fault_q = FaultNone;
      mode_q  = ModeCodeIdle;
    end
  endtask

  task automatic start_homing(input logic [31:0] at_ms);
    mode_q     = ModeCodeHoming;
    deadline_q = at_ms + 32'(homing_ms_q);
  endtask

  // Advance the predicted state by one event; queue the reply a command earns
  task automatic gate_event(input event_t ev);
    nack_e       verdict;
    reply_t      reply;
    logic [31:0] since_deadline;
    verdict = NK_NONE;
    case (ev.action)
      ACT_COMMAND: begin
        if (ev.command_code == CMD_ESTOP) begin
          set_estop_line(1'b1);
        end else if (ev.command_code > CMD_LAST_ALWAYS) begin
          verdict = NK_UNKNOWN;
        end else if (ev.command_code < NumGated &&
                     !AllowedModes[ev.command_code][mode_q]) begin
          if (mode_q == ModeCodeEstopped) verdict = NK_ESTOP;
          else if (mode_q == ModeCodeFaulted) verdict = NK_HWFAULT;
          else verdict = NK_NOTREADY;
        end else begin
          case (ev.command_code)
            CMD_HOME: start_homing(ev.now_ms);
            CMD_RUN_PROGRAM: begin
              if (ev.program_loaded) mode_q = ModeCodeRunning;
              else verdict = NK_NOPROG;
            end
            CMD_PAUSE:  mode_q = ModeCodePaused;
            CMD_RESUME: mode_q = ModeCodeRunning;
            CMD_RESET_FAULT: begin
              fault_q = FaultNone;
              mode_q  = ModeCodeIdle;
            end
            CMD_RESET_ESTOP: begin
              if (latch_q) begin
                verdict = NK_HWFAULT;
              end else begin
                fault_q = FaultNone;
                mode_q  = ModeCodeIdle;
              end
            end
            default: ;
          endcase
        end
        reply.reply_kind    = verdict != NK_NONE;
        reply.reply_tag     = ev.command_tag;
        reply.reply_command = ev.command_code;
        reply.nack_reason   = verdict;
        reply.mode_now      = mode_q;
        reply.estop_latched = latch_q;
        reply.fault_now     = fault_q;
        expected_replies.push_back(reply);
      end
      ACT_TICK: begin
        // wrap-safe: at or past the deadline when the difference is not negative
        since_deadline = ev.now_ms - deadline_q;
        if (mode_q == ModeCodeHoming && !since_deadline[31]) mode_q = ModeCodeReady;
      end
      ACT_BUTTON: begin
        case (ev.button_code)
          BTN_START: begin
            if (mode_q == ModeCodeIdle) start_homing(ev.now_ms);
            else if (mode_q == ModeCodeReady) begin
              if (ev.program_loaded) mode_q = ModeCodeRunning;
            end else if (mode_q == ModeCodePaused) mode_q = ModeCodeRunning;
          end
          BTN_PAUSE: begin
            if (mode_q == ModeCodeRunning) mode_q = ModeCodePaused;
            else if (mode_q == ModeCodeFaulted) begin
              fault_q = FaultNone;
              mode_q  = ModeCodeIdle;
            end
          end
          default: ;
        endcase
      end
      ACT_ESTOP: set_estop_line(ev.estop_level);
      ACT_FAULT: begin
        if (mode_q != ModeCodeEstopped) begin
          fault_q = ev.fault_reason;
          mode_q  = ModeCodeFaulted;
        end
      end
      default: ;
    endcase
  endtask

  // Queue one event; fields the event kind does not use stay random
  task automatic push_event(input logic [2:0] kind, input logic [4:0] code,
                            input logic [31:0] at_ms, input logic [7:0] detail,
                            input logic prog);
    event_t ev;
    ev.action         = kind;
    ev.command_code   = 5'($urandom);
    ev.command_tag    = 16'($urandom);
    ev.now_ms         = $urandom;
    ev.button_code    = 2'($urandom);
    ev.estop_level    = 1'($urandom);
    ev.fault_reason   = 8'($urandom);
    ev.program_loaded = prog;
    case (kind)
      ACT_COMMAND: begin
        ev.command_code = code;
        ev.now_ms       = at_ms;
      end
      ACT_TICK: ev.now_ms = at_ms;
      ACT_BUTTON: begin
        ev.button_code = detail[1:0];
        ev.now_ms      = at_ms;
      end
      ACT_ESTOP: ev.estop_level = detail[0];
      ACT_FAULT: ev.fault_reason = detail;
      default: ;
    endcase
    pending_events.push_back(ev);
    pushed_total++;
    if (kind <= ACT_FAULT) planned_items++;
  endtask

  task automatic random_operation(input logic [31:0] at_ms);
    logic prog;
    prog = $urandom_range(3) != 0;
    case ($urandom_range(11))
      0, 1: push_event(ACT_COMMAND, CMD_RUN_PROGRAM, at_ms, '0, prog);
      2: push_event(ACT_COMMAND, CMD_PAUSE, at_ms, '0, prog);
      3: push_event(ACT_COMMAND, CMD_RESUME, at_ms, '0, prog);
      4: push_event(ACT_BUTTON, '0, at_ms, 8'(BTN_START), prog);
      5: push_event(ACT_BUTTON, '0, at_ms, 8'(BTN_PAUSE), prog);
      6: push_event(ACT_COMMAND, 5'($urandom_range(NumGated - 1)), at_ms, '0, prog);
      7: push_event(ACT_COMMAND, 5'($urandom_range(CMD_ESTOP + 1, CMD_LAST_ALWAYS)),
                    at_ms, '0, prog);
      8: begin
        if ($urandom_range(1)) push_event(ACT_FAULT, '0, at_ms, 8'($urandom), prog);
        else push_event(ACT_COMMAND, CMD_RESET_FAULT, at_ms, '0, prog);
      end
      9: begin
        if ($urandom_range(1)) push_event(ACT_COMMAND, CMD_ESTOP, at_ms, '0, prog);
        else push_event(ACT_ESTOP, '0, at_ms, 8'($urandom_range(1)), prog);
      end
      10: push_event(ACT_TICK, '0, at_ms, '0, prog);
      default: begin
        if ($urandom_range(1)) push_event(ACT_COMMAND, CMD_HOME, at_ms, '0, prog);
        else push_event(ACT_COMMAND, CMD_RESET_ESTOP, at_ms, '0, prog);
      end
    endcase
  endtask

  // Mostly well-formed homing and recovery sessions, with some noise between them
  task automatic plan_phase(input int unsigned n_items, input int unsigned homing_ms);
    int unsigned target;
    int unsigned roll;
    logic [31:0] t0;
    target = planned_items + n_items;
    while (planned_items < target) begin
      roll = $urandom_range(99);
      t0   = gen_ms + $urandom_range(1, 2000);
      if (roll < 60) begin
        // drop back to idle through the estop line first, most of the time
        if ($urandom_range(9) < 7) begin
          push_event(ACT_ESTOP, '0, t0, 8'd1, 1'b0);
          push_event(ACT_ESTOP, '0, t0, 8'd0, 1'b0);
        end
        if ($urandom_range(1)) push_event(ACT_COMMAND, CMD_HOME, t0, '0, 1'($urandom));
        else push_event(ACT_BUTTON, '0, t0, 8'(BTN_START), 1'($urandom));
        repeat ($urandom_range(2))
          push_event(ACT_COMMAND, 5'($urandom_range(NumGated - 1)), t0, '0, 1'($urandom));
        repeat ($urandom_range(3)) begin
          if ($urandom_range(3) == 0)
            push_event(ACT_TICK, '0, t0 - $urandom_range(1, 1000), '0, 1'($urandom));
          else if (homing_ms != 0)
            push_event(ACT_TICK, '0, t0 + $urandom_range(homing_ms - 1), '0, 1'($urandom));
        end
        if ($urandom_range(1)) push_event(ACT_TICK, '0, t0 + homing_ms, '0, 1'($urandom));
        else push_event(ACT_TICK, '0, t0 + homing_ms + $urandom_range(500), '0,
                        1'($urandom));
        repeat ($urandom_range(2, 10))
          random_operation(t0 + homing_ms + $urandom_range(100));
        gen_ms = t0 + homing_ms + $urandom_range(5000);
      end else if (roll < 80) begin
        if ($urandom_range(1)) begin
          push_event(ACT_FAULT, '0, t0, 8'($urandom), 1'($urandom));
          push_event(ACT_COMMAND, 5'($urandom_range(NumGated - 1)), t0, '0, 1'($urandom));
          case ($urandom_range(2))
            0: push_event(ACT_COMMAND, CMD_RESET_FAULT, t0, '0, 1'($urandom));
            1: push_event(ACT_BUTTON, '0, t0, 8'(BTN_PAUSE), 1'($urandom));
            default: push_event(ACT_COMMAND, CMD_RESET_ESTOP, t0, '0, 1'($urandom));
          endcase
        end else begin
          if ($urandom_range(1)) push_event(ACT_ESTOP, '0, t0, 8'd1, 1'($urandom));
          else push_event(ACT_COMMAND, CMD_ESTOP, t0, '0, 1'($urandom));
          push_event(ACT_COMMAND, CMD_RESET_ESTOP, t0, '0, 1'($urandom));
          push_event(ACT_FAULT, '0, t0, 8'($urandom), 1'($urandom));
          push_event(ACT_COMMAND, 5'($urandom_range(NumGated - 1)), t0, '0, 1'($urandom));
          push_event(ACT_ESTOP, '0, t0, 8'($urandom_range(1)), 1'($urandom));
        end
        gen_ms = t0;
      end else begin
        repeat ($urandom_range(1, 4))
          push_event(3'($urandom), 5'($urandom), $urandom, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic wait_until_drained();
    do @(posedge clk_i);
    while (accepted_total != pushed_total || expected_replies.size() != 0);
    // non-command events leave no reply: give them time to settle
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_homing_time(input cfg_word_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i);
    while (!(cfg_ch.valid && cfg_ch.ready));
    homing_ms_q = value;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      error_count++;
    end
  endtask

  // Event driver: hold a word until taken, idle at random between words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (evt_ch.valid && evt_ch.ready) begin
        gate_event(evt_ch.data);
        accepted_total++;
      end
      if (!evt_ch.valid || evt_ch.ready) begin
        if (pending_events.size() != 0 && (quiet_stretch || $urandom_range(99) >= 15)) begin
          evt_ch.valid <= 1'b1;
          evt_ch.data  <= pending_events.pop_front();
        end else begin
          evt_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor
  always @(posedge clk_i) begin : reply_monitor
    reply_t want;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_replies.size() == 0) begin
          $error("reply with none expected: tag 0x%0h", res_ch.data.reply_tag);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("reply_kind", want.reply_kind, res_ch.data.reply_kind);
          check_field("reply_tag", want.reply_tag, res_ch.data.reply_tag);
          check_field("reply_command", want.reply_command, res_ch.data.reply_command);
          check_field("nack_reason", want.nack_reason, res_ch.data.nack_reason);
          check_field("mode_now", want.mode_now, res_ch.data.mode_now);
          check_field("estop_latched", want.estop_latched, res_ch.data.estop_latched);
          check_field("fault_now", want.fault_now, res_ch.data.fault_now);
        end
      end
      res_ch.ready <= quiet_stretch || $urandom_range(99) >= 15;
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        silent_cycles <= 0;
      end else if (silent_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        silent_cycles <= silent_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] t0;
    rst_ni         = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    evt_ch.valid   = 1'b0;
    evt_ch.data    = '0;
    res_ch.ready   = 1'b0;
    mode_q         = ModeCodeIdle;
    deadline_q     = '0;
    latch_q        = 1'b0;
    fault_q        = FaultNone;
    homing_ms_q    = HomingTimeReset;
    pushed_total   = 0;
    accepted_total = 0;
    planned_items  = 0;
    error_count    = 0;
    cycle_count    = 0;
    silent_cycles  = 0;
    gen_ms         = $urandom;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk through every mode; homing deadline wraps past zero
    t0 = 32'hFFFF_FF00;
    push_event(ACT_COMMAND, 5'h1F, '0, '0, 1'b1);
    push_event(ACT_COMMAND, CMD_RUN_PROGRAM, '0, '0, 1'b1);
    push_event(ACT_COMMAND, CMD_LAST_ALWAYS, 32'hFFFF_FFFF, '0, 1'b0);
    push_event(ACT_COMMAND, CMD_HOME, t0, '0, 1'b0);
    push_event(ACT_COMMAND, CMD_RESUME, t0, '0, 1'b0);
    push_event(ACT_TICK, '0, t0 + HomingTimeReset - 1, '0, 1'b0);
    push_event(ACT_TICK, '0, t0 + HomingTimeReset, '0, 1'b0);
    push_event(ACT_COMMAND, CMD_RUN_PROGRAM, t0, '0, 1'b0);
    push_event(ACT_BUTTON, '0, t0, 8'(BTN_START), 1'b0);
    push_event(ACT_BUTTON, '0, t0, 8'(BTN_START), 1'b1);
    push_event(ACT_COMMAND, CMD_PAUSE, t0, '0, 1'b0);
    push_event(ACT_COMMAND, CMD_RESUME, t0, '0, 1'b0);
    push_event(ACT_BUTTON, '0, t0, 8'(BTN_PAUSE), 1'b0);
    push_event(ACT_BUTTON, '0, t0, 8'(BtnIgnored), 1'b1);
    push_event(ACT_COMMAND, CMD_RESET_FAULT, t0, '0, 1'b0);
    push_event(ACT_FAULT, '0, t0, 8'h00, 1'b0);
    push_event(ACT_COMMAND, CMD_HOME, t0, '0, 1'b0);
    push_event(ACT_COMMAND, CMD_RESET_FAULT, t0, '0, 1'b0);
    push_event(ACT_FAULT, '0, t0, 8'(FaultEstopTriggered), 1'b0);
    push_event(ACT_BUTTON, '0, t0, 8'(BTN_PAUSE), 1'b0);
    push_event(ACT_ESTOP, '0, t0, 8'd1, 1'b0);
    push_event(ACT_FAULT, '0, t0, 8'hFF, 1'b0);
    push_event(ACT_COMMAND, CMD_RESET_ESTOP, t0, '0, 1'b0);
    push_event(ACT_COMMAND, CMD_HOME, t0, '0, 1'b0);
    push_event(ACT_ESTOP, '0, t0, 8'd0, 1'b0);
    push_event(ACT_COMMAND, CMD_ESTOP, t0, '0, 1'b1);
    push_event(ACT_ESTOP, '0, t0, 8'd0, 1'b0);
    push_event(3'(ACT_FAULT + 1 + $urandom_range(2)), '0, t0, '0, 1'b0);

    plan_phase(230, HomingTimeReset);
    wait_until_drained();
    write_homing_time('0);
    plan_phase(240, 0);
    wait_until_drained();
    write_homing_time('1);
    gen_ms = 32'hFFFF_0000;
    plan_phase(240, 16'hFFFF);
    wait_until_drained();
    write_homing_time(16'd1);
    plan_phase(240, 1);
    wait_until_drained();
    write_homing_time(cfg_word_t'($urandom_range(2, 16'hFFFE)));
    plan_phase(240, homing_ms_q);
    wait_until_drained();
    write_homing_time(HomingTimeReset);
    plan_phase(240, HomingTimeReset);
    wait_until_drained();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
